[src/fms_pkg.sv]
// ----------------------------------------------------------------------------
// fms_pkg: shared types and codes for the fuzzy match scorer
// word layouts, item kinds, match kinds and the per-cell control/status groups
// ----------------------------------------------------------------------------
package fms_pkg;

  // item kinds on the input channel
  localparam logic [1:0] KIND_APPEND = 2'd0;
  localparam logic [1:0] KIND_TARGET = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  // result classes
  localparam logic [1:0] MK_NONE   = 2'd0;
  localparam logic [1:0] MK_SUBSEQ = 2'd1;
  localparam logic [1:0] MK_SUBSTR = 2'd2;
  localparam logic [1:0] MK_EMPTY  = 2'd3;

  // score constants, in tenths
  localparam logic [9:0] SCORE_EMPTY    = 10'd10;
  localparam logic [9:0] SCORE_SUBSTR   = 10'd100;
  localparam logic [9:0] SCORE_PER_BYTE = 10'd10;
  localparam logic [9:0] SCORE_SUBSEQ   = 10'd50;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] char_byte;
    logic       last;
  } in_word_t;

  typedef struct packed {
    logic signed [9:0] score_tenths;
    logic [1:0]        match_kind;
    logic              accepted;
  } out_word_t;

  // broadcast from the top to every cell
  typedef struct packed {
    logic       step;     // target byte accepted
    logic       restart;  // clear per-target state
    logic       drop;     // query cleared
    logic [7:0] ch;       // folded byte
  } cell_ctl_t;

  // reported by every cell each cycle
  typedef struct packed {
    logic valid;      // cell holds a query byte
    logic miss;       // pointer sits here and byte differs
    logic tail_hit;   // full query ends at this byte
  } cell_stat_t;

  function automatic logic [7:0] fold(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= 8'h41 && b <= 8'h5a) begin
      r = b + 8'd32;
    end
    return r;
  endfunction

endpackage

[src/fms_cell.sv]
// ----------------------------------------------------------------------------
// fms_cell: one query position
// holds a query byte, its shift-and prefix bit and the subsequence token
// ----------------------------------------------------------------------------
module fms_cell #(
  parameter bit IS_FIRST = 1'b0
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  fms_pkg::cell_ctl_t     ctl,
  input  logic                   load,       // store ctl.ch here
  input  logic                   prefix_in,  // prefix bit of left neighbor
  input  logic                   tok_in,     // token handed from the left
  input  logic                   next_valid, // right neighbor holds a byte
  output logic                   prefix_out,
  output logic                   tok_out,
  output fms_pkg::cell_stat_t    stat
);

  logic [7:0] q_r;
  logic       v_r;
  logic       p_r, p_nxt;
  logic       tok_r, tok_nxt;
  logic       eq;

  assign eq         = v_r && (q_r == ctl.ch);
  assign p_nxt      = prefix_in && eq;
  assign tok_out    = tok_r && eq;
  assign tok_nxt    = (tok_r && !eq) || tok_in;
  assign prefix_out = p_r;

  assign stat.valid    = v_r;
  assign stat.miss     = tok_r && v_r && !eq;
  assign stat.tail_hit = p_nxt && v_r && !next_valid;

  always_ff @(posedge clk) begin
    if (load) begin
      q_r <= ctl.ch;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r   <= 1'b0;
      p_r   <= 1'b0;
      tok_r <= IS_FIRST;
    end else begin
      if (ctl.drop) begin
        v_r <= 1'b0;
      end else if (load) begin
        v_r <= 1'b1;
      end
      if (ctl.restart) begin
        p_r   <= 1'b0;
        tok_r <= IS_FIRST;
      end else if (ctl.step) begin
        p_r   <= p_nxt;
        tok_r <= tok_nxt;
      end
    end
  end

endmodule

[src/fuzzy_match_scorer.sv]
// ----------------------------------------------------------------------------
// fuzzy_match_scorer: streaming fuzzy match of a query against a target
// case-insensitive substring / subsequence scoring in a row of query cells
// ----------------------------------------------------------------------------
// usage:
//   in_ channel carries one word per item: append a query byte, clear the
//   query, or feed a target byte. the target byte flagged last produces one
//   result word on the out_ channel; every other item produces none.
//   appending or clearing the query restarts any target in progress.
// timing:
//   one item per cycle while in_ready is high. each query position is a cell;
//   on a target byte all cells compare in parallel, the prefix bit shifts one
//   cell right and the subsequence token hops at most one cell, so nothing
//   ripples along the row. the result appears in the output register the
//   cycle after the last target byte is taken.
// stalls:
//   the output register frees the input side: a new item is taken while the
//   result register is empty or is being emptied in the same cycle. while a
//   result waits on out_ready, in_ready is low.
// reset:
//   synchronous active-low rst_n empties the query, clears all per-target
//   state and the output valid flag. stored query bytes are not cleared.
// ----------------------------------------------------------------------------
module fuzzy_match_scorer #(
  parameter int QUERY_MAX = 16,
  parameter int GAP_MAX   = 63
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  fms_pkg::in_word_t    in_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output fms_pkg::out_word_t   out_word
);

  localparam int LW = $clog2(QUERY_MAX + 1);
  localparam int GW = $clog2(GAP_MAX + 1);

  // handshake and decode
  logic               in_fire;
  logic               is_append, is_clear, is_target, is_final;
  fms_pkg::cell_ctl_t ctl;

  // query length and per-target state
  logic [LW-1:0] len_r;
  logic          found_r;
  logic [GW-1:0] gap_r, gap_nxt;
  logic          found_nxt, done_nxt;

  // the cell row
  logic [QUERY_MAX:0]     prefix_chain;  // bit i feeds cell i
  logic [QUERY_MAX:0]     tok_chain;
  logic [QUERY_MAX:0]     valid_chain;   // bit i+1 is cell i's right neighbor
  fms_pkg::cell_stat_t    stat [QUERY_MAX];
  logic [QUERY_MAX-1:0]   miss_v, tail_v;
  logic [QUERY_MAX-1:0]   tok_hold_v;    // cell keeps or gets the token

  // result register
  logic               out_valid_r;
  fms_pkg::out_word_t out_word_r, res;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  assign is_append = in_fire && (in_word.kind == fms_pkg::KIND_APPEND);
  assign is_clear  = in_fire && (in_word.kind == fms_pkg::KIND_CLEAR);
  assign is_target = in_fire && (in_word.kind == fms_pkg::KIND_TARGET);
  assign is_final  = is_target && in_word.last;

  assign ctl.step    = is_target;
  assign ctl.restart = is_append || is_clear || is_final;
  assign ctl.drop    = is_clear;
  assign ctl.ch      = fms_pkg::fold(in_word.char_byte);

  // the left edge always extends a prefix
  assign prefix_chain[0]         = 1'b1;
  assign tok_chain[0]            = 1'b0;
  assign valid_chain[QUERY_MAX]  = 1'b0;

  for (genvar i = 0; i < QUERY_MAX; i++) begin : g_cell
    logic load_i;
    logic tok_pass;
    assign load_i = is_append && (len_r == LW'(i));

    fms_cell #(
      .IS_FIRST (i == 0)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .load       (load_i),
      .prefix_in  (prefix_chain[i]),
      .tok_in     (tok_chain[i]),
      .next_valid (valid_chain[i+1]),
      .prefix_out (prefix_chain[i+1]),
      .tok_out    (tok_pass),
      .stat       (stat[i])
    );

    assign tok_chain[i+1] = tok_pass;
    assign valid_chain[i] = stat[i].valid;
    assign miss_v[i]      = stat[i].miss;
    assign tail_v[i]      = stat[i].tail_hit;
    // token stays on a miss, arrives from the left on a match there
    assign tok_hold_v[i]  = stat[i].valid &&
                            (stat[i].miss || tok_chain[i]);
  end

  // state after this target byte
  always_comb begin
    found_nxt = found_r || (|tail_v);
    gap_nxt   = gap_r;
    if ((|miss_v) && (gap_r < GW'(GAP_MAX))) begin
      gap_nxt = gap_r + GW'(1);
    end
    // subsequence done once the token has left the valid cells
    done_nxt = !(|tok_hold_v);
  end

  // scoring
  always_comb begin
    res = '0;
    if (len_r == '0) begin
      res.score_tenths = fms_pkg::SCORE_EMPTY;
      res.match_kind   = fms_pkg::MK_EMPTY;
      res.accepted     = 1'b1;
    end else if (found_nxt) begin
      res.score_tenths = fms_pkg::SCORE_SUBSTR +
                         10'(len_r) * fms_pkg::SCORE_PER_BYTE;
      res.match_kind   = fms_pkg::MK_SUBSTR;
      res.accepted     = 1'b1;
    end else if (done_nxt) begin
      res.score_tenths = fms_pkg::SCORE_SUBSEQ - 10'(gap_nxt);
      res.match_kind   = fms_pkg::MK_SUBSEQ;
      res.accepted     = (10'(gap_nxt) < fms_pkg::SCORE_SUBSEQ);
    end else begin
      res.score_tenths = '0;
      res.match_kind   = fms_pkg::MK_NONE;
      res.accepted     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= '0;
      found_r <= 1'b0;
      gap_r   <= '0;
    end else begin
      if (is_clear) begin
        len_r <= '0;
      end else if (is_append && (len_r < LW'(QUERY_MAX))) begin
        len_r <= len_r + LW'(1);
      end
      if (ctl.restart) begin
        found_r <= 1'b0;
        gap_r   <= '0;
      end else if (is_target) begin
        found_r <= found_nxt;
        gap_r   <= gap_nxt;
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (is_final) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (is_final) begin
      out_word_r <= res;
    end
  end

endmodule
